// ===== rtl/akd_pkg.sv =====
// ----------------------------------------------------------------------------
// akd_pkg: shared types and constants of the analog keypad decoder
// Widths, key and event codes, the ladder thresholds and the classifier.
// ----------------------------------------------------------------------------
package akd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIMER_BITS  = 16;
    localparam int DELAY_BITS  = 16;
    localparam int CMP_BITS    = (TIMER_BITS > DELAY_BITS) ? TIMER_BITS : DELAY_BITS;
    localparam int CFG_IDX_BITS = 1;
    localparam int LADDER_BITS = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_DELAY = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEXT_DELAY  = 1'd1;

    localparam logic [DELAY_BITS-1:0] FIRST_DELAY_RST = DELAY_BITS'(500);
    localparam logic [DELAY_BITS-1:0] NEXT_DELAY_RST  = DELAY_BITS'(150);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Key mask bits.
    localparam logic [2:0] KEY_NONE   = 3'b000;
    localparam logic [2:0] KEY_UP     = 3'b001;
    localparam logic [2:0] KEY_DOWN   = 3'b010;
    localparam logic [2:0] KEY_SELECT = 3'b100;

    // Event codes.
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_PRESS  = 2'd1;
    localparam logic [1:0] EV_REPEAT = 2'd2;

    // Ladder thresholds.
    localparam logic [LADDER_BITS-1:0] LAD_FLOOR  = 16'd500;
    localparam logic [LADDER_BITS-1:0] LAD_UP     = 16'd580;
    localparam logic [LADDER_BITS-1:0] LAD_DOWN   = 16'd650;
    localparam logic [LADDER_BITS-1:0] LAD_SEL    = 16'd720;
    localparam logic [LADDER_BITS-1:0] LAD_UD     = 16'd765;
    localparam logic [LADDER_BITS-1:0] LAD_US     = 16'd794;
    localparam logic [LADDER_BITS-1:0] LAD_DS     = 16'd824;
    localparam logic [LADDER_BITS-1:0] LAD_ALL    = 16'd900;

    typedef struct packed {
        logic                   level_high;
        logic [SAMPLE_BITS-1:0] adc_sample;
    } t_item;

    // Maps one settled reading onto a button mask.
    function automatic logic [2:0] classify(input logic [SAMPLE_BITS-1:0] v);
        logic [LADDER_BITS-1:0] w;
        logic [2:0]             k;
        w = LADDER_BITS'(v);
        if (w <= LAD_FLOOR)    k = KEY_NONE;
        else if (w < LAD_UP)   k = KEY_UP;
        else if (w < LAD_DOWN) k = KEY_DOWN;
        else if (w < LAD_SEL)  k = KEY_SELECT;
        else if (w < LAD_UD)   k = KEY_UP | KEY_DOWN;
        else if (w < LAD_US)   k = KEY_UP | KEY_SELECT;
        else if (w < LAD_DS)   k = KEY_DOWN | KEY_SELECT;
        else if (w < LAD_ALL)  k = KEY_UP | KEY_DOWN | KEY_SELECT;
        else                   k = KEY_NONE;
        return k;
    endfunction

endpackage

// ===== rtl/akd_in_if.sv =====
// ----------------------------------------------------------------------------
// akd_in_if: input channel of the keypad decoder
// Valid/ready handshake carrying the comparator bit and the ADC reading.
// ----------------------------------------------------------------------------
interface akd_in_if;
    logic                           valid;
    logic                           ready;
    logic                           level_high;
    logic [akd_pkg::SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output level_high, output adc_sample, input ready);
    modport sink   (input valid, input level_high, input adc_sample, output ready);
endinterface

// ===== rtl/akd_out_if.sv =====
// ----------------------------------------------------------------------------
// akd_out_if: result channel of the keypad decoder
// Valid/ready handshake carrying key mask, event code and settled flag.
// ----------------------------------------------------------------------------
interface akd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_mask;
    logic [1:0] key_event;
    logic       settled;

    modport source (output valid, output key_mask, output key_event, output settled,
                    input ready);
    modport sink   (input valid, input key_mask, input key_event, input settled,
                    output ready);
endinterface

// ===== rtl/akd_in_stage.sv =====
// ----------------------------------------------------------------------------
// akd_in_stage: input register of the keypad decoder
// Holds one accepted word until the decode stage takes it.
// ----------------------------------------------------------------------------
module akd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    akd_in_if.sink          s_in,
    input  logic            i_take,
    output logic            o_valid,
    output akd_pkg::t_item  o_item
);

    logic           r_valid;
    akd_pkg::t_item r_item;
    logic           accept;

    // The register frees up in the same cycle that its word moves on.
    assign s_in.ready = !r_valid || i_take;
    assign accept     = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.level_high <= s_in.level_high;
            r_item.adc_sample <= s_in.adc_sample;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/akd_decode.sv =====
// ----------------------------------------------------------------------------
// akd_decode: settle check, ladder decode and auto-repeat timer
// Updates the key state and loads the result register for each word.
// ----------------------------------------------------------------------------
module akd_decode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  akd_pkg::t_item                     i_item,
    input  logic [akd_pkg::DELAY_BITS-1:0]     i_first_delay,
    input  logic [akd_pkg::DELAY_BITS-1:0]     i_next_delay,
    output logic                               o_take,
    akd_out_if.source                          m_out
);

    logic [akd_pkg::SAMPLE_BITS-1:0] r_prev;
    logic [2:0]                      r_held;
    logic [akd_pkg::TIMER_BITS-1:0]  r_ticks;
    logic                            r_short;
    logic                            r_out_valid;
    logic [2:0]                      r_mask;
    logic [1:0]                      r_event;
    logic                            r_settled;

    logic [akd_pkg::SAMPLE_BITS-1:0] n_prev;
    logic [2:0]                      n_held;
    logic [akd_pkg::TIMER_BITS-1:0]  n_ticks;
    logic                            n_short;
    logic [2:0]                      n_mask;
    logic [1:0]                      n_event;
    logic                            n_settled;

    logic [akd_pkg::TIMER_BITS-1:0]  ticks_inc;
    logic [akd_pkg::DELAY_BITS-1:0]  delay;
    logic [2:0]                      key;
    logic                            same;

    // A word moves on when the result register is empty or being emptied.
    assign o_take = i_valid && (!r_out_valid || m_out.ready);

    assign ticks_inc = (r_ticks == akd_pkg::TIMER_MAX) ? r_ticks
                                                       : r_ticks + 1'b1;
    assign delay = r_short ? i_next_delay : i_first_delay;
    assign key   = akd_pkg::classify(i_item.adc_sample);
    assign same  = (i_item.adc_sample == r_prev);

    always_comb begin
        n_prev    = r_prev;
        n_held    = r_held;
        n_ticks   = r_ticks;
        n_short   = r_short;
        n_mask    = akd_pkg::KEY_NONE;
        n_event   = akd_pkg::EV_NONE;
        n_settled = 1'b1;
        if (!i_item.level_high) begin
            // Comparator low: the key is released and all state clears.
            n_prev  = '0;
            n_held  = akd_pkg::KEY_NONE;
            n_ticks = '0;
            n_short = 1'b0;
        end else begin
            n_ticks   = ticks_inc;
            n_prev    = i_item.adc_sample;
            n_settled = same;
            if (same && (key != akd_pkg::KEY_NONE)) begin
                n_mask = key;
                if (key != r_held) begin
                    n_event = akd_pkg::EV_PRESS;
                    n_held  = key;
                    n_ticks = '0;
                    n_short = 1'b0;
                end else if (akd_pkg::CMP_BITS'(ticks_inc) >
                             akd_pkg::CMP_BITS'(delay)) begin
                    n_event = akd_pkg::EV_REPEAT;
                    n_ticks = '0;
                    n_short = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_held      <= akd_pkg::KEY_NONE;
            r_ticks     <= '0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_prev      <= n_prev;
                r_held      <= n_held;
                r_ticks     <= n_ticks;
                r_short     <= n_short;
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mask    <= n_mask;
            r_event   <= n_event;
            r_settled <= n_settled;
        end
    end

    assign m_out.valid     = r_out_valid;
    assign m_out.key_mask  = r_mask;
    assign m_out.key_event = r_event;
    assign m_out.settled   = r_settled;

endmodule

// ===== rtl/analog_keypad_decoder_repeat.sv =====
// ----------------------------------------------------------------------------
// analog_keypad_decoder_repeat: resistor-ladder keypad decoder with repeat
// Decodes a three-button ladder keypad into press and auto-repeat events.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake       Word
//   s_in     in         valid/ready     level_high, adc_sample
//   m_out    out        valid/ready     key_mask, key_event, settled
//   cfg      in         i_cfg_we only   i_cfg_idx, i_cfg_data
//
// Every word gives exactly one result word. An accepted word is held in
// the input register until the decode stage takes it. The decode stage
// is combinational and loads the result register when it takes a word.
// A new word is accepted in every cycle while results are taken. The rate is
// set by the single decode stage that updates the key state once per word.
// Reset is synchronous and active low. It restores the default delays and
// clears the key state. A stalled result register holds the decode stage,
// which in turn holds the input register.
//
module analog_keypad_decoder_repeat (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    akd_in_if.sink                              s_in,
    akd_out_if.source                           m_out,
    input  logic                                i_cfg_we,
    input  logic [akd_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [akd_pkg::DELAY_BITS-1:0]      i_cfg_data
);

    // Repeat delays. They are to be written only while the decoder is idle, so
    // the decode stage may read them directly; the block does not enforce this.
    logic [akd_pkg::DELAY_BITS-1:0] r_first_delay;
    logic [akd_pkg::DELAY_BITS-1:0] r_next_delay;

    logic           stage_valid;
    akd_pkg::t_item stage_item;
    logic           take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay <= akd_pkg::FIRST_DELAY_RST;
            r_next_delay  <= akd_pkg::NEXT_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                akd_pkg::CFG_FIRST_DELAY: r_first_delay <= i_cfg_data;
                akd_pkg::CFG_NEXT_DELAY:  r_next_delay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The input register decouples the source from the decode stage.
    akd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // The decode stage settles, classifies and times each word and loads
    // the result register.
    akd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (stage_valid),
        .i_item        (stage_item),
        .i_first_delay (r_first_delay),
        .i_next_delay  (r_next_delay),
        .o_take        (take),
        .m_out         (m_out)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the analog keypad decoder with repeat
// Drives comparator and ADC words through the input channel with random
// gaps, takes result words with random stalls, and checks each one against
// an in-bench model of the ladder, the press logic and the repeat timer.
// ----------------------------------------------------------------------------
module tb;
    import akd_pkg::*;

    // One result word as the decoder presents it.
    typedef struct packed {
        logic [2:0] key_mask;
        logic [1:0] key_event;
        logic       settled;
    } t_key_result;

    // One row of the directed table. When typed is set, the result in the
    // row is the one expected; otherwise the model decides.
    typedef struct packed {
        logic                   level_high;
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic                   typed;
        t_key_result            result;
    } t_stim_row;

    localparam int NUM_ROWS    = 24;
    localparam int ITEM_TARGET = 1350;
    localparam int NUM_PHASES  = 8;
    localparam int MAX_IDLE    = 12;
    localparam int TAIL_CYCLES = 8;
    localparam int RESET_CYCLES = 10;
    // Length of the final hold under the largest delays.
    localparam int LONG_HOLD   = 40;
    localparam int PHASE_ITEMS = (ITEM_TARGET - NUM_ROWS - LONG_HOLD) / NUM_PHASES;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [SAMPLE_BITS-1:0] ALL_KEYS_LEVEL = 10'd860;

    // Readings on and next to every threshold of the ladder, plus the ends.
    localparam logic [SAMPLE_BITS-1:0] LADDER_EDGES [18] = '{
        10'd0,   10'd500, 10'd501, 10'd579, 10'd580, 10'd649,
        10'd650, 10'd719, 10'd720, 10'd764, 10'd765, 10'd793,
        10'd794, 10'd823, 10'd824, 10'd899, 10'd900, 10'd1023
    };

    // The directed walk starts right after reset, when the previous reading
    // is zero. Each band is entered with two equal readings: the first one
    // is unsettled, the second one gives the press.
    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        // Comparator low: no key, settled.
        '{1'b0, 10'd1023, 1'b1, '{KEY_NONE, EV_NONE, 1'b1}},
        // Zero equals the cleared previous reading, but lies below the ladder.
        '{1'b1, 10'd0,    1'b1, '{KEY_NONE, EV_NONE, 1'b1}},
        // Top of the range: first unsettled, then settled above the ladder.
        '{1'b1, 10'd1023, 1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd1023, 1'b1, '{KEY_NONE, EV_NONE, 1'b1}},
        '{1'b1, 10'd501,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd501,  1'b1, '{KEY_UP, EV_PRESS, 1'b1}},
        '{1'b1, 10'd580,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd580,  1'b1, '{KEY_DOWN, EV_PRESS, 1'b1}},
        '{1'b1, 10'd650,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd650,  1'b1, '{KEY_SELECT, EV_PRESS, 1'b1}},
        '{1'b1, 10'd720,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd720,  1'b1, '{KEY_UP | KEY_DOWN, EV_PRESS, 1'b1}},
        '{1'b1, 10'd765,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd765,  1'b1, '{KEY_UP | KEY_SELECT, EV_PRESS, 1'b1}},
        '{1'b1, 10'd794,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd794,  1'b1, '{KEY_DOWN | KEY_SELECT, EV_PRESS, 1'b1}},
        '{1'b1, 10'd899,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd899,  1'b1, '{KEY_UP | KEY_DOWN | KEY_SELECT, EV_PRESS, 1'b1}},
        // The floor itself is no key; the held key survives it.
        '{1'b1, 10'd500,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        '{1'b1, 10'd500,  1'b1, '{KEY_NONE, EV_NONE, 1'b1}},
        '{1'b1, 10'd899,  1'b1, '{KEY_NONE, EV_NONE, 1'b0}},
        // Same key again: no new press, the timer decides.
        '{1'b1, 10'd899,  1'b0, '{KEY_NONE, EV_NONE, 1'b0}},
        // Release, then a zero reading that matches the cleared history.
        '{1'b0, 10'd0,    1'b1, '{KEY_NONE, EV_NONE, 1'b1}},
        '{1'b1, 10'd0,    1'b1, '{KEY_NONE, EV_NONE, 1'b1}}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [DELAY_BITS-1:0]   i_cfg_data;

    akd_in_if  in_ch ();
    akd_out_if out_ch ();

    analog_keypad_decoder_repeat i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (in_ch),
        .m_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Model state and its copy of the delay registers, at reset values.
    logic [DELAY_BITS-1:0]  first_delay = FIRST_DELAY_RST;
    logic [DELAY_BITS-1:0]  next_delay  = NEXT_DELAY_RST;
    logic [SAMPLE_BITS-1:0] last_sample = '0;
    logic [2:0]             held_key    = KEY_NONE;
    logic [TIMER_BITS-1:0]  hold_ticks  = '0;
    logic                   short_delay = 1'b0;

    // Results that accepted input words still owe, oldest first.
    t_key_result pending_results [$];

    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    // When set, the side in question runs back to back with no idling.
    bit send_no_idle = 1'b0;
    bit recv_no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Maps a reading onto the button mask of its band of the ladder.
    function automatic logic [2:0] ladder_mask(input logic [SAMPLE_BITS-1:0] v);
        int unsigned x;
        x = v;
        if (x <= LAD_FLOOR || x >= LAD_ALL) return KEY_NONE;
        if (x < LAD_UP)   return KEY_UP;
        if (x < LAD_DOWN) return KEY_DOWN;
        if (x < LAD_SEL)  return KEY_SELECT;
        if (x < LAD_UD)   return KEY_UP | KEY_DOWN;
        if (x < LAD_US)   return KEY_UP | KEY_SELECT;
        if (x < LAD_DS)   return KEY_DOWN | KEY_SELECT;
        return KEY_UP | KEY_DOWN | KEY_SELECT;
    endfunction

    // Advances the model by one input word and returns the result it gives.
    function automatic t_key_result decode_tick(input logic level,
                                                input logic [SAMPLE_BITS-1:0] sample);
        t_key_result           r;
        logic [2:0]            k;
        logic [DELAY_BITS-1:0] delay;
        r = '{KEY_NONE, EV_NONE, 1'b1};
        if (!level) begin
            // Key released: all history is dropped.
            held_key    = KEY_NONE;
            hold_ticks  = '0;
            short_delay = 1'b0;
            last_sample = '0;
        end else begin
            if (hold_ticks != TIMER_MAX) begin
                hold_ticks = hold_ticks + 1'b1;
            end
            r.settled   = (sample == last_sample);
            last_sample = sample;
            k = ladder_mask(sample);
            if (r.settled && k != KEY_NONE) begin
                r.key_mask = k;
                if (k != held_key) begin
                    r.key_event = EV_PRESS;
                    held_key    = k;
                    hold_ticks  = '0;
                    short_delay = 1'b0;
                end else begin
                    delay = short_delay ? next_delay : first_delay;
                    if (CMP_BITS'(hold_ticks) > CMP_BITS'(delay)) begin
                        r.key_event = EV_REPEAT;
                        hold_ticks  = '0;
                        short_delay = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Picks a reading: a ladder edge, somewhere inside the ladder, or anything.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 2))
            0:       return LADDER_EDGES[$urandom_range(0, 17)];
            1:       return SAMPLE_BITS'($urandom_range(LAD_FLOOR + 1, LAD_ALL - 1));
            default: return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
        endcase
    endfunction

    function automatic logic [DELAY_BITS-1:0] draw_delay();
        // Mostly short delays so that repeats happen within a hold.
        if ($urandom_range(0, 4) == 0) begin
            return DELAY_BITS'($urandom_range(0, (1 << DELAY_BITS) - 1));
        end
        return DELAY_BITS'($urandom_range(0, MAX_IDLE));
    endfunction

    // Presents one input word after a random gap and waits for it to be
    // taken. The model runs at the accepting edge. Valid is only lowered
    // when a gap follows, so it is never dropped and raised in one step.
    task automatic send_word(input logic level, input logic [SAMPLE_BITS-1:0] sample,
                             input logic typed, input t_key_result typed_res);
        int unsigned gap;
        t_key_result r;
        gap = send_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.level_high <= level;
        in_ch.adc_sample <= sample;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        r = decode_tick(level, sample);
        pending_results.push_back(typed ? typed_res : r);
        words_sent++;
    endtask

    task automatic feed(input logic level, input logic [SAMPLE_BITS-1:0] sample);
        send_word(level, sample, 1'b0, '0);
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Rewrites both delay registers while the decoder is idle. The key
    // state is left alone, so a held key carries over into the new setting.
    task automatic write_delays(input logic [DELAY_BITS-1:0] first_val,
                                input logic [DELAY_BITS-1:0] next_val);
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_DELAY;
        i_cfg_data <= first_val;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_NEXT_DELAY;
        i_cfg_data <= next_val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        first_delay = first_val;
        next_delay  = next_val;
    endtask

    // One stretch of random stimulus. Most stretches are steady key holds,
    // since only a reading repeated on consecutive words gets past the
    // settling check; the rest is noise, idling changes and full drains.
    task automatic run_episode();
        int unsigned            kind;
        int unsigned            len;
        int unsigned            glitch_at;
        logic [SAMPLE_BITS-1:0] s;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            s   = pick_sample();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 20);
            // Sometimes one reading in the hold is disturbed, which must not
            // give a second press once the reading settles again.
            glitch_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
            for (int t = 1; t <= len; t++) begin
                feed(1'b1, (t == glitch_at) ? pick_sample() : s);
            end
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) begin
                    feed(1'b0, SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
                end
            end
        end else if (kind < 17) begin
            repeat ($urandom_range(1, 6)) begin
                feed(1'($urandom_range(0, 1)),
                     SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
            end
        end else if (kind < 19) begin
            send_no_idle = ($urandom_range(0, 3) == 0);
            recv_no_idle = ($urandom_range(0, 3) == 0);
        end else begin
            drain();
        end
    endtask

    // Compares one taken result word with the oldest one owed.
    task automatic check_result();
        t_key_result got;
        t_key_result want;
        got = '{out_ch.key_mask, out_ch.key_event, out_ch.settled};
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result word %0d not expected: mask %0d event %0d settled %0d",
                         results_seen, got.key_mask, got.key_event, got.settled);
            end
        end else begin
            want = pending_results.pop_front();
            if (got.key_mask !== want.key_mask || got.key_event !== want.key_event ||
                got.settled !== want.settled) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result word %0d: expected mask %0d event %0d settled %0d, %s",
                             results_seen, want.key_mask, want.key_event, want.settled,
                             $sformatf("got mask %0d event %0d settled %0d",
                                       got.key_mask, got.key_event, got.settled));
                end
            end
        end
        results_seen++;
    endtask

    // Result side: a random stall before each word, ready held high after.
    initial begin : result_sink
        int unsigned stall;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = recv_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && out_ch.valid === 1'b1));
            check_result();
        end
    end

    // Ends a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("no progress within %0d cycles", CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned           phase_start;
        logic [DELAY_BITS-1:0] f;
        logic [DELAY_BITS-1:0] n;

        in_ch.valid      = 1'b0;
        in_ch.level_high = 1'b0;
        in_ch.adc_sample = '0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_FIRST_DELAY;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk across the ladder, with the reset delays in force.
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_word(DIRECTED_ROWS[i].level_high, DIRECTED_ROWS[i].adc_sample,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        end
        // The sender holds off until the decoder has nothing left to give.
        drain();

        // Random phases, each with its own delay pair. Phase 0 keeps the reset
        // values, phases 1, 3 and 4 take range ends, the rest small or random.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                case (ph)
                    1:       begin f = '0;       n = '0;       end
                    2:       begin f = 16'd2;    n = 16'd1;    end
                    3:       begin f = '0;       n = '1;       end
                    4:       begin f = '1;       n = '0;       end
                    7:       begin f = 16'd6;    n = 16'd3;    end
                    default: begin f = draw_delay(); n = draw_delay(); end
                endcase
                write_delays(f, n);
            end
            send_no_idle = ($urandom_range(0, 3) == 0);
            recv_no_idle = ($urandom_range(0, 3) == 0);
            phase_start  = words_sent;
            while (words_sent - phase_start < PHASE_ITEMS) begin
                run_episode();
            end
        end

        // Steady hold with the largest delays: the timer never gets past
        // them within this hold, so no repeat may fire.
        write_delays('1, '1);
        send_no_idle = 1'b1;
        recv_no_idle = 1'b1;
        repeat (LONG_HOLD) feed(1'b1, ALL_KEYS_LEVEL);
        feed(1'b0, '0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/akd_pkg.sv
rtl/akd_in_if.sv
rtl/akd_out_if.sv
rtl/akd_in_stage.sv
rtl/akd_decode.sv
rtl/analog_keypad_decoder_repeat.sv
verif/tb.sv
